FILE: sv/hrts_pkg.sv
// Shared constants and types for the HV rail trim sequencer.
package hrts_pkg;

  localparam int unsigned ReadW  = 15;
  localparam int unsigned PCodeW = 12;
  localparam int unsigned NCodeW = 8;
  localparam int unsigned TicksW = 16;
  localparam int unsigned TryW   = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned InDataW  = 112;
  localparam int unsigned OutDataW = 32;

  localparam int unsigned FineTriesDefault = 20;

  localparam logic [PCodeW-1:0] PosHigh = 12'd2457;
  localparam logic [PCodeW-1:0] PosLow  = 12'd447;
  localparam logic [PCodeW-1:0] PosStep = 12'd3;
  localparam logic [NCodeW-1:0] NegHigh = 8'd247;
  localparam logic [NCodeW-1:0] NegLow  = 8'd46;
  localparam logic [NCodeW-1:0] NegStep = 8'd2;
  localparam logic [ReadW:0]    TrackGap = 16'd150;

  // phase codes
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhWait = 2'd1;
  localparam logic [1:0] PhFine = 2'd2;
  localparam logic [1:0] PhMon  = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegMinPos  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegMaxPos  = 3'd1;
  localparam logic [CfgIdxW-1:0] RegMinNeg  = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMaxNeg  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSettle  = 3'd4;
  localparam logic [CfgIdxW-1:0] RegTrimTol = 3'd5;

  // input item as packed on tdata, last field lowest
  typedef struct packed {
    logic [1:0]        pad;
    logic [ReadW-1:0]  neg_volt_goal;
    logic [ReadW-1:0]  pos_volt_goal;
    logic [NCodeW-1:0] neg_code_goal;
    logic [PCodeW-1:0] pos_code_goal;
    logic [ReadW-1:0]  neg_sibling;
    logic [ReadW-1:0]  pos_sibling;
    logic [ReadW-1:0]  neg_reading;
    logic [ReadW-1:0]  pos_reading;
  } in_item_t;

  typedef struct packed {
    logic [4:0]        pad;
    logic              track_fault;
    logic              over_fault;
    logic              trim_done;
    logic [1:0]        phase_now;
    logic              neg_write;
    logic              pos_write;
    logic [NCodeW-1:0] neg_code;
    logic [PCodeW-1:0] pos_code;
  } out_item_t;

  function automatic logic [ReadW-1:0] abs_diff(logic [ReadW-1:0] a, logic [ReadW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: sv/hv_rail_trim_sequencer.sv
// Top level of the HV rail trim sequencer: input register, phase logic, result register.
// One item per clock is sustained while the output side is free. An accepted transfer
// lands in the input register, and once the output side can take it the phase/trim logic
// runs once on it and loads the result register, which then offers the result. The phase
// and code state update in that single stage, so each item sees what the
// previous one left. Configuration writes are taken every cycle (cfg_ready_o is high) and
// must only happen while the block is idle; register indexes above five are ignored.
module hv_rail_trim_sequencer #(
  parameter int unsigned FINE_TRIES = hrts_pkg::FineTriesDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // pos_reading, neg_reading, pos_sibling, neg_sibling, pos_code_goal, neg_code_goal,
  // pos_volt_goal, neg_volt_goal
  input  logic [hrts_pkg::InDataW-1:0]  s_axis_tdata_i,
  // kind
  input  logic                          s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // pos_code, neg_code, pos_write, neg_write, phase_now, trim_done, over_fault, track_fault
  output logic [hrts_pkg::OutDataW-1:0] m_axis_tdata_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [hrts_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [hrts_pkg::CfgDataW-1:0] cfg_data_i
);
  import hrts_pkg::*;

  localparam logic [TryW-1:0] TriesMax = TryW'(FINE_TRIES);

  // configuration
  logic [ReadW-1:0]  min_pos_q, max_pos_q, min_neg_q, max_neg_q, trim_tol_q;
  logic [TicksW-1:0] settle_q;

  // sequencer state
  logic [1:0]        phase_q, phase_d;
  logic [PCodeW-1:0] pos_code_q, pos_code_d;
  logic [NCodeW-1:0] neg_code_q, neg_code_d;
  logic [ReadW-1:0]  pos_goal_q, pos_goal_d, neg_goal_q, neg_goal_d;
  logic [TicksW-1:0] wait_ticks_q, wait_ticks_d;
  logic [TryW-1:0]   try_q, try_d;

  // pipeline registers
  logic      in_valid_q;
  in_item_t  in_item_q;
  logic      in_kind_q;
  logic      out_valid_q;
  out_item_t out_q, out_d;
  logic      fire;

  assign fire            = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_pos_q  <= '0;
      max_pos_q  <= '1;
      min_neg_q  <= '0;
      max_neg_q  <= '1;
      settle_q   <= TicksW'(100);
      trim_tol_q <= ReadW'(10);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegMinPos:  min_pos_q  <= cfg_data_i[ReadW-1:0];
        RegMaxPos:  max_pos_q  <= cfg_data_i[ReadW-1:0];
        RegMinNeg:  min_neg_q  <= cfg_data_i[ReadW-1:0];
        RegMaxNeg:  max_neg_q  <= cfg_data_i[ReadW-1:0];
        RegSettle:  settle_q   <= cfg_data_i;
        RegTrimTol: trim_tol_q <= cfg_data_i[ReadW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_item_q <= in_item_t'(s_axis_tdata_i);
      in_kind_q <= s_axis_tuser_i;
    end
  end

  // phase and trim logic
  always_comb begin
    logic [ReadW-1:0]  rp, rn, sp, sn;
    logic [ReadW-1:0]  err_p, err_n;
    logic              in_window;
    logic              done, over, track, pw, nw;

    rp = in_item_q.pos_reading;
    rn = in_item_q.neg_reading;
    sp = in_item_q.pos_sibling;
    sn = in_item_q.neg_sibling;

    phase_d      = phase_q;
    pos_code_d   = pos_code_q;
    neg_code_d   = neg_code_q;
    pos_goal_d   = pos_goal_q;
    neg_goal_d   = neg_goal_q;
    wait_ticks_d = wait_ticks_q;
    try_d        = try_q;
    done  = 1'b0;
    over  = 1'b0;
    track = 1'b0;
    pw    = 1'b0;
    nw    = 1'b0;

    err_p = abs_diff(rp, pos_goal_q);
    err_n = abs_diff(rn, neg_goal_q);
    in_window = (rp >= min_pos_q) && (rp <= max_pos_q) &&
                (rn >= min_neg_q) && (rn <= max_neg_q);

    if (in_kind_q) begin
      // start: load goals, abandon any phase in progress
      if (in_item_q.pos_code_goal != pos_code_q || in_item_q.neg_code_goal != neg_code_q) begin
        pw = 1'b1;
        nw = 1'b1;
      end
      pos_code_d   = in_item_q.pos_code_goal;
      neg_code_d   = in_item_q.neg_code_goal;
      pos_goal_d   = in_item_q.pos_volt_goal;
      neg_goal_d   = in_item_q.neg_volt_goal;
      wait_ticks_d = '0;
      try_d        = '0;
      phase_d      = PhWait;
    end else if (phase_q == PhMon) begin
      over  = (rp >= max_pos_q) || (rn >= max_neg_q);
      // compare with the gap added on the reading side to avoid underflow
      track = (({1'b0, rp} + TrackGap) < {1'b0, sp}) ||
              (({1'b0, rn} + TrackGap) < {1'b0, sn});
      if (over || track) begin
        phase_d = PhIdle;
      end
    end else begin
      if (phase_q == PhWait) begin
        if (wait_ticks_q <= settle_q) begin
          if (in_window) begin
            phase_d = PhFine;
            try_d   = '0;
          end
        end else begin
          phase_d = PhFine;
        end
        if (wait_ticks_q != '1) begin
          wait_ticks_d = wait_ticks_q + TicksW'(1);
        end
      end
      if (phase_d == PhFine) begin
        try_d = try_d + TryW'(1);
        if (try_d >= TriesMax || (err_p < trim_tol_q && err_n < trim_tol_q)) begin
          try_d        = '0;
          wait_ticks_d = '0;
          done         = 1'b1;
          phase_d      = PhMon;
        end else begin
          if (err_p > trim_tol_q) begin
            pw = 1'b1;
            if (rp > pos_goal_q) begin
              pos_code_d = (pos_code_q >= PosHigh - PosStep) ? PosHigh : pos_code_q + PosStep;
            end else begin
              pos_code_d = (pos_code_q <= PosLow + PosStep) ? PosLow : pos_code_q - PosStep;
            end
          end
          if (err_n > trim_tol_q) begin
            nw = 1'b1;
            if (rn > neg_goal_q) begin
              neg_code_d = (neg_code_q >= NegHigh - NegStep) ? NegHigh : neg_code_q + NegStep;
            end else begin
              neg_code_d = (neg_code_q <= NegLow + NegStep) ? NegLow : neg_code_q - NegStep;
            end
          end
        end
      end
    end

    out_d             = '0;
    out_d.pos_code    = pos_code_d;
    out_d.neg_code    = neg_code_d;
    out_d.pos_write   = pw;
    out_d.neg_write   = nw;
    out_d.phase_now   = phase_d;
    out_d.trim_done   = done;
    out_d.over_fault  = over;
    out_d.track_fault = track;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhIdle;
      pos_code_q   <= '0;
      neg_code_q   <= '0;
      pos_goal_q   <= '0;
      neg_goal_q   <= '0;
      wait_ticks_q <= '0;
      try_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (fire) begin
        phase_q      <= phase_d;
        pos_code_q   <= pos_code_d;
        neg_code_q   <= neg_code_d;
        pos_goal_q   <= pos_goal_d;
        neg_goal_q   <= neg_goal_d;
        wait_ticks_q <= wait_ticks_d;
        try_q        <= try_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  // hold the result until the transfer completes
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= out_d;
    end
  end

endmodule

FILE: dv/tb_hv_rail_trim_sequencer.sv
// Self-checking testbench for the HV rail trim sequencer: directed and random stream traffic.
`timescale 1ns / 1ps

module tb_hv_rail_trim_sequencer;
  import hrts_pkg::*;

  localparam int   FineTries    = FineTriesDefault;
  localparam logic KindTick     = 1'b0;
  localparam logic KindStart    = 1'b1;
  localparam int   RxHoldCycles = 400;
  localparam int   PhaseItems   = 170;
  localparam int   RandomPhases = 8;
  localparam int   ReadMax      = 32767;

  // Tracks the sequencer state and queues the result due for every accepted item.
  class trim_scoreboard;
    int         lim_min_pos, lim_max_pos, lim_min_neg, lim_max_neg;
    int         settle_limit, tolerance;
    logic [1:0] phase;
    int         code_pos, code_neg, goal_pos, goal_neg, ticks_waited, tries;
    out_item_t  rail_results_q[$];
    int         errors;

    function new();
      lim_min_pos  = 0;
      lim_max_pos  = ReadMax;
      lim_min_neg  = 0;
      lim_max_neg  = ReadMax;
      settle_limit = 100;
      tolerance    = 10;
      phase        = PhIdle;
      code_pos     = 0;
      code_neg     = 0;
      goal_pos     = 0;
      goal_neg     = 0;
      ticks_waited = 0;
      tries        = 0;
      errors       = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegMinPos:  lim_min_pos  = int'(val[ReadW-1:0]);
        RegMaxPos:  lim_max_pos  = int'(val[ReadW-1:0]);
        RegMinNeg:  lim_min_neg  = int'(val[ReadW-1:0]);
        RegMaxNeg:  lim_max_neg  = int'(val[ReadW-1:0]);
        RegSettle:  settle_limit = int'(val);
        RegTrimTol: tolerance    = int'(val[ReadW-1:0]);
        default: ;
      endcase
    endfunction

    function int magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    // Move a code one step toward the goal, pinning it to the band edge.
    function int step_toward(int code, int err, int step, int lo, int hi);
      if (err > 0) return (code + step >= hi) ? hi : code + step;
      if (err < 0) return (code - step <= lo) ? lo : code - step;
      return code;
    endfunction

    function void note_input(logic kind, in_item_t d);
      out_item_t r;
      int        rp, rn, sp, sn, ep, en;
      logic      pw, nw, done, over, track;
      r     = '0;
      pw    = 1'b0;
      nw    = 1'b0;
      done  = 1'b0;
      over  = 1'b0;
      track = 1'b0;
      rp    = int'(d.pos_reading);
      rn    = int'(d.neg_reading);
      sp    = int'(d.pos_sibling);
      sn    = int'(d.neg_sibling);
      if (kind == KindStart) begin
        if (int'(d.pos_code_goal) != code_pos || int'(d.neg_code_goal) != code_neg) begin
          pw = 1'b1;
          nw = 1'b1;
        end
        code_pos     = int'(d.pos_code_goal);
        code_neg     = int'(d.neg_code_goal);
        goal_pos     = int'(d.pos_volt_goal);
        goal_neg     = int'(d.neg_volt_goal);
        ticks_waited = 0;
        tries        = 0;
        phase        = PhWait;
      end else if (phase == PhMon) begin
        over  = (rp >= lim_max_pos) || (rn >= lim_max_neg);
        track = (rp < sp - int'(TrackGap)) || (rn < sn - int'(TrackGap));
        if (over || track) phase = PhIdle;
      end else begin
        if (phase == PhWait) begin
          if (ticks_waited <= settle_limit) begin
            if (rp >= lim_min_pos && rp <= lim_max_pos &&
                rn >= lim_min_neg && rn <= lim_max_neg) begin
              phase = PhFine;
              tries = 0;
            end
          end else begin
            phase = PhFine;
          end
          if (ticks_waited < 65535) ticks_waited++;
        end
        // a fine step follows on the same tick that leaves waiting
        if (phase == PhFine) begin
          ep    = rp - goal_pos;
          en    = rn - goal_neg;
          tries = (tries + 1) % 32;
          if (tries >= FineTries ||
              (magnitude(ep) < tolerance && magnitude(en) < tolerance)) begin
            tries        = 0;
            ticks_waited = 0;
            done         = 1'b1;
            phase        = PhMon;
          end else begin
            if (magnitude(ep) > tolerance) begin
              code_pos = step_toward(code_pos, ep, int'(PosStep), int'(PosLow), int'(PosHigh));
              pw       = 1'b1;
            end
            if (magnitude(en) > tolerance) begin
              code_neg = step_toward(code_neg, en, int'(NegStep), int'(NegLow), int'(NegHigh));
              nw       = 1'b1;
            end
          end
        end
      end
      r.pos_code    = code_pos[PCodeW-1:0];
      r.neg_code    = code_neg[NCodeW-1:0];
      r.pos_write   = pw;
      r.neg_write   = nw;
      r.phase_now   = phase;
      r.trim_done   = done;
      r.over_fault  = over;
      r.track_fault = track;
      rail_results_q.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (rail_results_q.size() == 0) begin
        $error("result transfer with nothing expected: %h", got);
        errors++;
        return;
      end
      want = rail_results_q.pop_front();
      compare_field("pos_code",    16'(want.pos_code),    16'(got.pos_code));
      compare_field("neg_code",    16'(want.neg_code),    16'(got.neg_code));
      compare_field("pos_write",   16'(want.pos_write),   16'(got.pos_write));
      compare_field("neg_write",   16'(want.neg_write),   16'(got.neg_write));
      compare_field("phase_now",   16'(want.phase_now),   16'(got.phase_now));
      compare_field("trim_done",   16'(want.trim_done),   16'(got.trim_done));
      compare_field("over_fault",  16'(want.over_fault),  16'(got.over_fault));
      compare_field("track_fault", 16'(want.track_fault), 16'(got.track_fault));
    endfunction

    function int pending();
      return rail_results_q.size();
    endfunction
  endclass

  logic                clk_i     = 1'b0;
  logic                rst_ni    = 1'b0;
  logic                s_tvalid  = 1'b0;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                s_tuser   = 1'b0;
  logic                m_tready  = 1'b0;
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  logic                s_axis_tready_o;
  logic                m_axis_tvalid_o;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic                cfg_ready_o;

  trim_scoreboard trim_sb;
  int             sent_items  = 0;
  int             tx_mode_left = 0;
  bit             tx_calm     = 1'b0;
  bit             rx_hold_req = 1'b0;

  always #1 clk_i = ~clk_i;

  hv_rail_trim_sequencer #(
    .FINE_TRIES(FineTries)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  function automatic in_item_t tick_item(int rp, int rn, int sp, int sn);
    in_item_t d;
    // goal fields are ignored on a tick: fill them with noise
    d             = in_item_t'(InDataW'({$urandom, $urandom, $urandom, $urandom}));
    d.pad         = '0;
    d.pos_reading = ReadW'(rp);
    d.neg_reading = ReadW'(rn);
    d.pos_sibling = ReadW'(sp);
    d.neg_sibling = ReadW'(sn);
    return d;
  endfunction

  function automatic in_item_t start_item(int pcg, int ncg, int pvg, int nvg);
    in_item_t d;
    d               = in_item_t'(InDataW'({$urandom, $urandom, $urandom, $urandom}));
    d.pad           = '0;
    d.pos_code_goal = PCodeW'(pcg);
    d.neg_code_goal = NCodeW'(ncg);
    d.pos_volt_goal = ReadW'(pvg);
    d.neg_volt_goal = ReadW'(nvg);
    return d;
  endfunction

  function automatic logic [ReadW-1:0] near(int centre, int spread);
    int v;
    v = centre + int'($urandom_range(0, 2 * spread)) - spread;
    if (v < 0) v = 0;
    else if (v > ReadMax) v = ReadMax;
    return v[ReadW-1:0];
  endfunction

  function automatic logic [ReadW-1:0] bound_reading(int lo, int hi);
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return ReadMax[ReadW-1:0];
      2:       return lo[ReadW-1:0];
      default: return hi[ReadW-1:0];
    endcase
  endfunction

  task automatic send(input logic kind, input in_item_t d);
    int gap;
    if (tx_mode_left == 0) begin
      tx_calm      = ($urandom_range(0, 3) == 0);
      tx_mode_left = $urandom_range(20, 60);
    end
    tx_mode_left--;
    gap = tx_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready_o);
    trim_sb.note_input(kind, d);
    sent_items++;
  endtask

  // Hold valid across back-to-back writes; the caller drops it afterwards.
  task automatic put_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    trim_sb.write_reg(idx, val);
  endtask

  task automatic configure(input int min_p, input int max_p, input int min_n,
                           input int max_n, input int settle, input int tol);
    // the spare top bit of the 15-bit registers must be discarded
    put_reg(RegMinPos,  {1'($urandom), 15'(min_p)});
    put_reg(RegMaxPos,  {1'($urandom), 15'(max_p)});
    put_reg(RegMinNeg,  {1'($urandom), 15'(min_n)});
    put_reg(RegMaxNeg,  {1'($urandom), 15'(max_n)});
    put_reg(RegSettle,  16'(settle));
    put_reg(RegTrimTol, {1'($urandom), 15'(tol)});
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (trim_sb.pending() > 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One start followed by ticks whose readings hover around the voltage goals.
  task automatic trim_sequence();
    logic [ReadW-1:0] pvg, nvg, rp, rn, sp, sn;
    int               spread, ticks;
    pvg = ReadW'($urandom_range(0, ReadMax));
    nvg = ReadW'($urandom_range(0, ReadMax));
    case ($urandom_range(0, 3))
      0:       spread = 4;
      1:       spread = 40;
      2:       spread = 300;
      default: spread = 4000;
    endcase
    ticks = $urandom_range(2, 30);
    send(KindStart, start_item($urandom_range(0, 4095), $urandom_range(0, 255), pvg, nvg));
    for (int i = 0; i < ticks; i++) begin
      rp = near(pvg, spread);
      rn = near(nvg, spread);
      if ($urandom_range(0, 7) == 0) rp = bound_reading(trim_sb.lim_min_pos, trim_sb.lim_max_pos);
      if ($urandom_range(0, 7) == 0) rn = bound_reading(trim_sb.lim_min_neg, trim_sb.lim_max_neg);
      if (trim_sb.phase == PhMon) begin
        sp = near(rp, 300);
        sn = near(rn, 300);
        if ($urandom_range(0, 5) == 0) rp = near(trim_sb.lim_max_pos, 2);
        if ($urandom_range(0, 5) == 0) rn = near(trim_sb.lim_max_neg, 2);
      end else begin
        sp = ReadW'($urandom_range(0, ReadMax));
        sn = ReadW'($urandom_range(0, ReadMax));
      end
      send(KindTick, tick_item(rp, rn, sp, sn));
      if (trim_sb.phase == PhIdle && $urandom_range(0, 1) == 0) break;
    end
  endtask

  initial begin : result_sink
    int gap, calm_left;
    bit calm;
    calm_left = 0;
    calm      = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm_left == 0) begin
        calm      = ($urandom_range(0, 3) == 0);
        calm_left = $urandom_range(20, 60);
      end
      calm_left--;
      gap = calm ? 0 : $urandom_range(0, 7);
      if (rx_hold_req) begin
        gap         = RxHoldCycles;
        rx_hold_req = 1'b0;
      end
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      trim_sb.check_result(out_item_t'(m_axis_tdata_o));
    end
  end

  initial begin : stimulus
    int phase_end;
    trim_sb = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    configure(0, ReadMax, 0, ReadMax, 100, 10);

    // directed: idle tick, unchanged codes, clamping from outside the band
    send(KindTick,  tick_item($urandom, $urandom, $urandom, $urandom));
    send(KindStart, start_item(0, 0, 1000, 1000));
    send(KindStart, start_item(4095, 255, 0, 0));
    send(KindTick,  tick_item(ReadMax, ReadMax, 0, 0));
    send(KindTick,  tick_item(ReadMax, ReadMax, 0, 0));
    send(KindStart, start_item(0, 0, ReadMax, ReadMax));
    send(KindTick,  tick_item(0, 0, 0, 0));
    // error equal to tolerance on the positive rail: no step there
    send(KindTick,  tick_item(ReadMax - 10, 0, 0, 0));
    send(KindTick,  tick_item(ReadMax - 7, ReadMax - 7, 0, 0));
    // monitoring: sibling below the tracking gap, then over-voltage
    send(KindTick,  tick_item(500, 0, 400, 149));
    send(KindTick,  tick_item(ReadMax, 500, 0, 0));
    send(KindTick,  tick_item(1234, 4321, 0, 0));
    send(KindStart, start_item(1000, 100, 2000, 3000));
    send(KindTick,  tick_item(2000, 3000, 0, 0));
    send(KindTick,  tick_item(100, 3000, 400, 0));
    send(KindStart, start_item(1000, 100, 2000, 3000));
    send(KindTick,  tick_item(2000, 3000, 0, 0));
    // both faults at once
    send(KindTick,  tick_item(ReadMax, 0, 0, ReadMax));
    send(KindStart, start_item(2457, 247, 5000, 5000));
    send(KindTick,  tick_item(5100, 4900, 0, 0));
    // restart during fine trim and during monitoring
    send(KindStart, start_item(447, 46, 6000, 6000));
    send(KindTick,  tick_item(5000, 7000, 0, 0));
    send(KindTick,  tick_item(6000, 6000, 0, 0));
    send(KindStart, start_item(2000, 200, 6000, 6000));
    drain();

    // narrow windows and no settle time: out of window once, then timeout
    configure(1000, 2000, 1000, 2000, 0, 3);
    send(KindStart, start_item(1500, 150, 1500, 1500));
    send(KindTick,  tick_item(5000, 1500, 0, 0));
    send(KindTick,  tick_item(5000, 1500, 0, 0));

    for (int p = 0; p < RandomPhases; p++) begin
      drain();
      case (p)
        0: configure(0, ReadMax, 0, ReadMax, 0, 0);
        1: configure(ReadMax, ReadMax, ReadMax, ReadMax, 65535, ReadMax);
        default: configure($urandom_range(0, 12000), $urandom_range(14000, ReadMax),
                           $urandom_range(0, 12000), $urandom_range(14000, ReadMax),
                           $urandom_range(0, 30), $urandom_range(0, 60));
      endcase
      if (p == 2) rx_hold_req = 1'b1;
      phase_end = sent_items + PhaseItems;
      while (sent_items < phase_end) begin
        if ($urandom_range(0, 6) == 0)
          send($urandom_range(0, 3) == 0 ? KindStart : KindTick,
               in_item_t'(InDataW'({$urandom, $urandom, $urandom, $urandom}) &
                          {2'b00, {(InDataW-2){1'b1}}}));
        else
          trim_sequence();
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (trim_sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin : watchdog
    #1_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
